>>> design/vsq_pkg.sv
// Shared constants, types and helper functions of the voxel surface and corner query block.
// Used by the controller, the datapath and the top level; depends on nothing else.
package vsq_pkg;

  localparam int AXIS_BITS  = 5;
  localparam int LABEL_BITS = 16;

  localparam int COORD_W    = 6;
  localparam int SIZE_W     = 6;
  localparam int OCC_W      = 16;
  localparam int LABEL_IN_W = 16;
  localparam int DIFF_W     = 3;
  localparam int CLASS_W    = 2;
  localparam int DIGIT_W    = 2;
  localparam int REG_IDX_W  = 2;

  localparam int CMP_W      = (SIZE_W > AXIS_BITS + 1) ? SIZE_W : AXIS_BITS + 1;
  localparam int AXIS_MAX   = 1 << AXIS_BITS;
  localparam int ADDR_W     = 3 * AXIS_BITS;
  localparam int CELL_COUNT = 1 << ADDR_W;
  localparam int CELL_W     = CLASS_W + LABEL_BITS;

  localparam int IN_FIELDS_W = 3 * COORD_W + OCC_W + LABEL_IN_W;
  localparam int IN_DATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_DATA_W  = 8;
  localparam int PADDR_W     = 4;
  localparam int PDATA_W     = 32;

  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(32);
  localparam logic [OCC_W-1:0]  OCC_HALF   = OCC_W'(32768);

  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef logic [CLASS_W-1:0] occ_class_t;
  localparam occ_class_t CLASS_EMPTY   = 2'd0;
  localparam occ_class_t CLASS_UNKNOWN = 2'd1;
  localparam occ_class_t CLASS_FILLED  = 2'd2;

  typedef logic [DIGIT_W-1:0] digit_t;
  localparam digit_t DIGIT_LOW  = 2'd0;
  localparam digit_t DIGIT_MID  = 2'd1;
  localparam digit_t DIGIT_HIGH = 2'd2;

  typedef logic [REG_IDX_W-1:0] reg_idx_t;
  localparam reg_idx_t REG_SIZE_X = 2'd0;
  localparam reg_idx_t REG_SIZE_Y = 2'd1;
  localparam reg_idx_t REG_SIZE_Z = 2'd2;

  typedef struct packed {
    logic capture;
    logic write_cell;
    logic scan_first;
    logic scan_next;
    logic load_out;
  } vsq_cmd_t;

  typedef struct packed {
    logic in_bounds;
    logic is_query;
    logic scan_last;
    logic out_free;
  } vsq_stat_t;

  function automatic logic [CMP_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
    logic [CMP_W-1:0] wide;
    wide = CMP_W'(v);
    if (wide > CMP_W'(AXIS_MAX)) begin
      return CMP_W'(AXIS_MAX);
    end
    return wide;
  endfunction

  function automatic occ_class_t occ_class(input logic [OCC_W-1:0] occ);
    if (occ < OCC_HALF) begin
      return CLASS_EMPTY;
    end else if (occ == OCC_HALF) begin
      return CLASS_UNKNOWN;
    end
    return CLASS_FILLED;
  endfunction

endpackage

>>> design/vsq_ctrl.sv
// Controller state machine of the voxel surface and corner query block.
// Sequences capture, cell write, neighbor scan and result load; uses vsq_pkg.
module vsq_ctrl
  import vsq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      s_tvalid,
  output logic      s_tready,
  input  vsq_stat_t stat,
  output vsq_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_SCAN,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  state_t state;
  logic   ready;

  assign s_tready = ready;

  always_comb begin
    cmd            = '0;
    cmd.capture    = ready && s_tvalid;
    cmd.scan_first = (state == ST_DECIDE) && stat.in_bounds && stat.is_query;
    cmd.write_cell = (state == ST_DECIDE) && stat.in_bounds && !stat.is_query;
    cmd.scan_next  = (state == ST_SCAN);
    cmd.load_out   = (state == ST_FINISH) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      ready <= 1'b1;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (ready && s_tvalid) begin
            state <= ST_DECIDE;
            ready <= 1'b0;
          end
        end
        ST_DECIDE: begin
          if (stat.in_bounds && stat.is_query) begin
            state <= ST_SCAN;
          end else begin
            state <= ST_FINISH;
          end
        end
        ST_SCAN: begin
          if (stat.scan_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (stat.out_free) begin
            state <= ST_IDLE;
            ready <= 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
          ready <= 1'b1;
        end
      endcase
    end
  end

endmodule

>>> design/vsq_dp.sv
// Datapath of the voxel surface and corner query block: size registers, item registers,
// cell memory, neighbor address generation, compare accumulators and output register.
module vsq_dp
  import vsq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  vsq_cmd_t              cmd,
  output vsq_stat_t             stat,
  input  logic [IN_DATA_W-1:0]  s_tdata,
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]    prdata
);

  logic [SIZE_W-1:0] size_x;
  logic [SIZE_W-1:0] size_y;
  logic [SIZE_W-1:0] size_z;
  reg_idx_t          reg_idx;

  assign reg_idx = paddr[PADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      size_x <= SIZE_RESET;
      size_y <= SIZE_RESET;
      size_z <= SIZE_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        REG_SIZE_X: size_x <= pwdata[SIZE_W-1:0];
        REG_SIZE_Y: size_y <= pwdata[SIZE_W-1:0];
        REG_SIZE_Z: size_z <= pwdata[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_SIZE_X: prdata = PDATA_W'(size_x);
      REG_SIZE_Y: prdata = PDATA_W'(size_y);
      REG_SIZE_Z: prdata = PDATA_W'(size_z);
      default:    prdata = '0;
    endcase
  end

  logic                  item_mode;
  logic [COORD_W-1:0]    item_x;
  logic [COORD_W-1:0]    item_y;
  logic [COORD_W-1:0]    item_z;
  occ_class_t            item_class;
  logic [LABEL_BITS-1:0] item_label;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_mode  <= s_tuser;
      item_x     <= s_tdata[COORD_W-1:0];
      item_y     <= s_tdata[2*COORD_W-1:COORD_W];
      item_z     <= s_tdata[3*COORD_W-1:2*COORD_W];
      item_class <= occ_class(s_tdata[3*COORD_W+OCC_W-1:3*COORD_W]);
      item_label <= s_tdata[3*COORD_W+OCC_W+LABEL_BITS-1:3*COORD_W+OCC_W];
    end
  end

  logic [CMP_W-1:0] eff_x;
  logic [CMP_W-1:0] eff_y;
  logic [CMP_W-1:0] eff_z;
  logic             in_bounds;
  logic             border;

  assign eff_x     = eff_size(size_x);
  assign eff_y     = eff_size(size_y);
  assign eff_z     = eff_size(size_z);
  assign in_bounds = (CMP_W'(item_x) < eff_x) && (CMP_W'(item_y) < eff_y)
                  && (CMP_W'(item_z) < eff_z);
  assign border    = (item_x == '0) || (item_y == '0) || (item_z == '0)
                  || (CMP_W'(item_x) == eff_x - CMP_W'(1))
                  || (CMP_W'(item_y) == eff_y - CMP_W'(1))
                  || (CMP_W'(item_z) == eff_z - CMP_W'(1));

  function automatic logic [AXIS_BITS-1:0] nb_coord(input logic [COORD_W-1:0] c,
                                                     input digit_t d);
    logic [AXIS_BITS-1:0] base;
    base = c[AXIS_BITS-1:0];
    case (d)
      DIGIT_LOW:  return base - AXIS_BITS'(1);
      DIGIT_HIGH: return base + AXIS_BITS'(1);
      default:    return base;
    endcase
  endfunction

  function automatic logic nb_ok(input logic [COORD_W-1:0] c, input digit_t d,
                                 input logic [CMP_W-1:0] eff);
    case (d)
      DIGIT_LOW:  return c != '0;
      DIGIT_HIGH: return (CMP_W'(c) + CMP_W'(1)) < eff;
      default:    return 1'b1;
    endcase
  endfunction

  digit_t ox;
  digit_t oy;
  digit_t oz;
  logic   nb_in_grid;
  logic   nb_face;

  assign nb_in_grid = nb_ok(item_x, ox, eff_x) && nb_ok(item_y, oy, eff_y)
                   && nb_ok(item_z, oz, eff_z);
  assign nb_face    = $countones({ox == DIGIT_MID, oy == DIGIT_MID, oz == DIGIT_MID}) == 2;

  always_ff @(posedge clk) begin
    if (cmd.scan_first) begin
      ox <= DIGIT_LOW;
      oy <= DIGIT_LOW;
      oz <= DIGIT_LOW;
    end else if (cmd.scan_next) begin
      if (ox != DIGIT_HIGH) begin
        ox <= ox + DIGIT_W'(1);
      end else begin
        ox <= DIGIT_LOW;
        if (oy != DIGIT_HIGH) begin
          oy <= oy + DIGIT_W'(1);
        end else begin
          oy <= DIGIT_LOW;
          oz <= oz + DIGIT_W'(1);
        end
      end
    end
  end

  logic [ADDR_W-1:0] mem_addr;
  logic [CELL_W-1:0] mem [CELL_COUNT];
  logic [CELL_W-1:0] rd_data;

  always_comb begin
    if (cmd.scan_next) begin
      mem_addr = {nb_coord(item_z, oz), nb_coord(item_y, oy), nb_coord(item_x, ox)};
    end else begin
      mem_addr = {item_z[AXIS_BITS-1:0], item_y[AXIS_BITS-1:0], item_x[AXIS_BITS-1:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.write_cell) begin
      mem[mem_addr] <= {item_class, item_label};
    end
    rd_data <= mem[mem_addr];
  end

  logic tag_center;
  logic tag_valid;
  logic tag_face;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_center <= 1'b0;
      tag_valid  <= 1'b0;
      tag_face   <= 1'b0;
    end else begin
      tag_center <= cmd.scan_first;
      tag_valid  <= cmd.scan_next && nb_in_grid;
      tag_face   <= nb_face;
    end
  end

  occ_class_t            rd_class;
  logic [LABEL_BITS-1:0] rd_label;
  occ_class_t            ctr_class;
  logic [LABEL_BITS-1:0] ctr_label;
  logic                  occ_surf;
  logic [DIFF_W-1:0]     diff_cnt;

  assign rd_class = rd_data[CELL_W-1:LABEL_BITS];
  assign rd_label = rd_data[LABEL_BITS-1:0];

  always_ff @(posedge clk) begin
    if (cmd.scan_first) begin
      occ_surf <= 1'b0;
      diff_cnt <= '0;
    end else if (tag_valid) begin
      if (rd_class != ctr_class) begin
        occ_surf <= 1'b1;
      end
      if (tag_face && (rd_label != ctr_label)) begin
        diff_cnt <= diff_cnt + DIFF_W'(1);
      end
    end
    if (tag_center) begin
      ctr_class <= rd_class;
      ctr_label <= rd_label;
    end
  end

  logic              out_valid;
  logic              out_inb;
  logic              out_occ_surf;
  logic              out_comp_surf;
  logic              out_corner;
  logic [DIFF_W-1:0] out_diff;
  logic              query_hit;

  assign query_hit = (item_mode == MODE_QUERY) && in_bounds;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_inb       <= in_bounds;
      out_occ_surf  <= query_hit && occ_surf;
      out_comp_surf <= query_hit && (border || (diff_cnt != '0));
      out_corner    <= query_hit && (diff_cnt >= DIFF_W'(2));
      out_diff      <= query_hit ? diff_cnt : '0;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = OUT_DATA_W'({out_diff, out_corner, out_comp_surf, out_occ_surf, out_inb});

  assign stat.in_bounds = in_bounds;
  assign stat.is_query  = item_mode == MODE_QUERY;
  assign stat.scan_last = (ox == DIGIT_HIGH) && (oy == DIGIT_HIGH) && (oz == DIGIT_HIGH);
  assign stat.out_free  = !out_valid || m_tready;

  a_center_after_first: assert property (@(posedge clk) disable iff (rst)
    tag_center |-> $past(cmd.scan_first))
    else $error("center tag without a preceding scan start");

  a_scan_only_query: assert property (@(posedge clk) disable iff (rst)
    tag_valid |-> (item_mode == MODE_QUERY))
    else $error("neighbor read tagged during a write item");

  a_corner_is_surface: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_corner || out_comp_surf))
    else $error("corner flagged on a voxel that is not a component surface");

  a_oob_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_inb) |-> (m_tdata == '0))
    else $error("out-of-bounds result carries nonzero flags");

endmodule

>>> design/voxel_surface_and_corner_query.sv
// Top level of the voxel surface and corner query block.
// Joins the controller vsq_ctrl and the datapath vsq_dp; uses vsq_pkg.
//
// Channel   Direction  Handshake                 Payload
// s_*       in         s_tvalid / s_tready       s_tdata voxel and cell fields, s_tuser mode
// m_*       out        m_tvalid / m_tready       m_tdata query result flags and count
// APB       in         psel, penable, pwrite     size_x, size_y, size_z at 0x0, 0x4, 0x8
//
// A query word passes the states decide, scan, drain and finish: the center cell and the
// 27 positions of its 3x3x3 block are read one a cycle through the single cell memory
// port, and drain waits for the last read. A write or out-of-bounds word goes from decide
// straight to finish. Each load returns the controller to idle, and no word is taken
// until the previous one is loaded. The next word is accepted while the previous result
// waits in the output register; a result that finds that register still full waits until
// it drains. Reset is synchronous; cell memory contents stay undefined until written.
module voxel_surface_and_corner_query
  import vsq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  // s_tdata: x_index[5:0], y_index[11:6], z_index[17:12], occupancy[33:18],
  // component_label[49:34], zero fill above.
  input  logic [IN_DATA_W-1:0]  s_tdata,
  // s_tuser: mode.
  input  logic                  s_tuser,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // m_tdata: in_bounds[0], occupancy_surface[1], component_surface[2],
  // candidate_corner[3], differing_faces[6:4], zero fill above.
  output logic [OUT_DATA_W-1:0] m_tdata,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [PADDR_W-1:0]    paddr,
  input  logic [PDATA_W-1:0]    pwdata,
  output logic [PDATA_W-1:0]    prdata,
  output logic                  pready
);

  vsq_cmd_t  cmd;
  vsq_stat_t stat;

  assign pready = 1'b1;

  vsq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  vsq_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata)
  );

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the voxel surface and corner query block.
// Drives cell writes and voxel queries, predicts every result word and compares it.
// Depends on vsq_pkg and the top level voxel_surface_and_corner_query.
module testbench;
  import vsq_pkg::*;

  localparam int PHASE_WORDS = 145;
  localparam int HOLD_AT     = 500;
  localparam int HOLD_CYCLES = 300;
  localparam int GAP_PCT     = 8;
  localparam reg_idx_t REG_SPARE = 2'd3;

  typedef struct packed {
    logic                  mode;
    logic [COORD_W-1:0]    x;
    logic [COORD_W-1:0]    y;
    logic [COORD_W-1:0]    z;
    logic [OCC_W-1:0]      occ;
    logic [LABEL_IN_W-1:0] lab;
  } voxel_word_t;

  typedef struct packed {
    logic              in_bounds;
    logic              occ_surface;
    logic              comp_surface;
    logic              corner;
    logic [DIFF_W-1:0] faces;
  } voxel_flags_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  // s_tdata: x_index, y_index, z_index, occupancy, component_label, zero fill.
  logic [IN_DATA_W-1:0]  s_tdata = '0;
  // s_tuser: mode.
  logic                  s_tuser = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  // m_tdata: in_bounds, occupancy_surface, component_surface, candidate_corner,
  // differing_faces, zero fill.
  logic [OUT_DATA_W-1:0] m_tdata;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [PADDR_W-1:0]    paddr = '0;
  logic [PDATA_W-1:0]    pwdata = '0;
  logic [PDATA_W-1:0]    prdata;
  logic                  pready;

  voxel_word_t  pending_words[$];
  voxel_flags_t flags_expected[$];
  voxel_word_t  word_on_bus;

  logic [SIZE_W-1:0]     grid_size [3];
  occ_class_t            class_mem [CELL_COUNT];
  logic [LABEL_BITS-1:0] label_mem [CELL_COUNT];
  bit                    gen_written [CELL_COUNT];

  int unsigned words_in = 0;
  int unsigned results_seen = 0;
  int unsigned hold_left = 0;
  bit          hold_fired = 1'b0;
  int          errors = 0;
  int          in_grid_words = 0;

  occ_class_t            bias_class;
  logic [LABEL_IN_W-1:0] label_base;
  int                    win_lo [3];
  int                    win_span [3];
  int                    phase_sizes [13][3] = '{
    '{3, 3, 3}, '{1, 1, 1}, '{32, 32, 32}, '{4, 2, 5}, '{63, 63, 63}, '{2, 1, 3},
    '{1, 32, 1}, '{5, 5, 5}, '{32, 3, 0}, '{6, 4, 3}, '{2, 2, 2}, '{1, 1, 33},
    '{63, 1, 2}
  };

  voxel_surface_and_corner_query dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic int axis_limit(int a);
    int s;
    s = int'(grid_size[a]);
    return (s > AXIS_MAX) ? AXIS_MAX : s;
  endfunction

  function automatic bit in_grid(int x, int y, int z);
    return x >= 0 && y >= 0 && z >= 0 &&
           x < axis_limit(0) && y < axis_limit(1) && z < axis_limit(2);
  endfunction

  function automatic int cell_index(int x, int y, int z);
    return (x & (AXIS_MAX - 1)) | ((y & (AXIS_MAX - 1)) << AXIS_BITS) |
           ((z & (AXIS_MAX - 1)) << (2 * AXIS_BITS));
  endfunction

  function automatic voxel_flags_t surface_predict(voxel_word_t w);
    voxel_flags_t          f;
    int                    x, y, z, a, n, faces;
    occ_class_t            own_class;
    logic [LABEL_BITS-1:0] own_label;
    bit                    border;
    f = '0;
    x = int'(w.x);
    y = int'(w.y);
    z = int'(w.z);
    if (!in_grid(x, y, z)) begin
      return f;
    end
    f.in_bounds = 1'b1;
    a = cell_index(x, y, z);
    if (w.mode == MODE_WRITE) begin
      if (w.occ < OCC_HALF) begin
        class_mem[a] = CLASS_EMPTY;
      end else if (w.occ == OCC_HALF) begin
        class_mem[a] = CLASS_UNKNOWN;
      end else begin
        class_mem[a] = CLASS_FILLED;
      end
      label_mem[a] = w.lab[LABEL_BITS-1:0];
      return f;
    end
    own_class = class_mem[a];
    own_label = label_mem[a];
    faces = 0;
    for (int dx = -1; dx <= 1; dx++) begin
      for (int dy = -1; dy <= 1; dy++) begin
        for (int dz = -1; dz <= 1; dz++) begin
          if ((dx != 0 || dy != 0 || dz != 0) && in_grid(x + dx, y + dy, z + dz)) begin
            n = cell_index(x + dx, y + dy, z + dz);
            if (class_mem[n] != own_class) begin
              f.occ_surface = 1'b1;
            end
            if (((dx != 0) + (dy != 0) + (dz != 0)) == 1 && label_mem[n] != own_label) begin
              faces++;
            end
          end
        end
      end
    end
    border = x == 0 || y == 0 || z == 0 || x == axis_limit(0) - 1 ||
             y == axis_limit(1) - 1 || z == axis_limit(2) - 1;
    f.comp_surface = border || faces > 0;
    f.corner = faces >= 2;
    f.faces = faces[DIFF_W-1:0];
    return f;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        flags_expected.push_back(surface_predict(word_on_bus));
        words_in <= words_in + 1;
      end
      if (!s_tvalid || s_tready) begin
        if (pending_words.size() != 0 &&
            !(($urandom_range(0, 99) < GAP_PCT) && !(words_in >= 1000 && words_in < 1300))) begin
          word_on_bus = pending_words.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= IN_DATA_W'({word_on_bus.lab, word_on_bus.occ, word_on_bus.z,
                                 word_on_bus.y, word_on_bus.x});
          s_tuser <= word_on_bus.mode;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (!hold_fired && words_in == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_fired <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  task automatic check_field(string name, int want, int got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    voxel_flags_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        results_seen <= results_seen + 1;
        if (flags_expected.size() == 0) begin
          $error("result word 0x%02h arrived with nothing expected", m_tdata);
          errors++;
        end else begin
          want = flags_expected.pop_front();
          check_field("in_bounds", int'(want.in_bounds), int'(m_tdata[0]));
          check_field("occupancy_surface", int'(want.occ_surface), int'(m_tdata[1]));
          check_field("component_surface", int'(want.comp_surface), int'(m_tdata[2]));
          check_field("candidate_corner", int'(want.corner), int'(m_tdata[3]));
          check_field("differing_faces", int'(want.faces), int'(m_tdata[6:4]));
          check_field("zero fill", 0, int'(m_tdata[OUT_DATA_W-1:7]));
        end
      end
      m_tready <= (hold_left == 0) &&
                  ((results_seen >= 900 && results_seen < 1300) ||
                   $urandom_range(0, 99) >= GAP_PCT);
    end
  end

  task automatic reg_write(reg_idx_t idx, logic [SIZE_W-1:0] val);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= PADDR_W'({idx, 2'b00});
    pwdata <= PDATA_W'(val);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_SIZE_X: grid_size[0] = val;
      REG_SIZE_Y: grid_size[1] = val;
      REG_SIZE_Z: grid_size[2] = val;
      default: ;
    endcase
  endtask

  task automatic set_grid(int sx, int sy, int sz);
    reg_write(REG_SIZE_X, sx[SIZE_W-1:0]);
    reg_write(REG_SIZE_Y, sy[SIZE_W-1:0]);
    reg_write(REG_SIZE_Z, sz[SIZE_W-1:0]);
  endtask

  task automatic wait_drained();
    while (!(pending_words.size() == 0 && !s_tvalid && flags_expected.size() == 0)) begin
      @(posedge clk);
    end
    repeat (4) @(posedge clk);
  endtask

  task automatic queue_word(logic mode, int x, int y, int z, logic [OCC_W-1:0] occ,
                            logic [LABEL_IN_W-1:0] lab);
    voxel_word_t w;
    w.mode = mode;
    w.x = x[COORD_W-1:0];
    w.y = y[COORD_W-1:0];
    w.z = z[COORD_W-1:0];
    w.occ = occ;
    w.lab = lab;
    pending_words.push_back(w);
    if (in_grid(x, y, z)) begin
      in_grid_words++;
      if (mode == MODE_WRITE) begin
        gen_written[cell_index(x, y, z)] = 1'b1;
      end
    end
  endtask

  function automatic logic [OCC_W-1:0] occ_of_class(occ_class_t c);
    if (c == CLASS_EMPTY) begin
      return OCC_W'($urandom_range(0, OCC_HALF - 1));
    end else if (c == CLASS_UNKNOWN) begin
      return OCC_HALF;
    end
    return OCC_W'($urandom_range(OCC_HALF + 1, 65535));
  endfunction

  function automatic logic [OCC_W-1:0] rand_occ();
    int r;
    r = $urandom_range(0, 9);
    if (r < 6) begin
      return occ_of_class(bias_class);
    end else if (r == 6) begin
      return OCC_HALF;
    end else if (r == 7) begin
      return $urandom_range(0, 1) ? OCC_HALF - OCC_W'(1) : OCC_HALF + OCC_W'(1);
    end
    return OCC_W'($urandom);
  endfunction

  function automatic logic [LABEL_IN_W-1:0] rand_label();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) begin
      return label_base ^ LABEL_IN_W'($urandom_range(0, 1));
    end else if (r == 7) begin
      return $urandom_range(0, 1) ? '1 : '0;
    end
    return LABEL_IN_W'($urandom);
  endfunction

  function automatic int pick_coord(int a);
    if ($urandom_range(0, 9) == 0) begin
      return $urandom_range(0, axis_limit(a) - 1);
    end
    return win_lo[a] + $urandom_range(0, win_span[a] - 1);
  endfunction

  // Writes every never-written cell that a query of this voxel would read.
  task automatic fill_block(int x, int y, int z);
    for (int dx = -1; dx <= 1; dx++) begin
      for (int dy = -1; dy <= 1; dy++) begin
        for (int dz = -1; dz <= 1; dz++) begin
          if (in_grid(x + dx, y + dy, z + dz) &&
              !gen_written[cell_index(x + dx, y + dy, z + dz)]) begin
            queue_word(MODE_WRITE, x + dx, y + dy, z + dz, rand_occ(), rand_label());
          end
        end
      end
    end
  endtask

  task automatic random_phase();
    int                    x, y, z, r, a, lim;
    int                    c[3];
    occ_class_t            uniform_class;
    logic [LABEL_IN_W-1:0] lab;
    if (axis_limit(0) == 0 || axis_limit(1) == 0 || axis_limit(2) == 0) begin
      repeat (30) begin
        queue_word(1'($urandom_range(0, 1)), $urandom_range(0, 63), $urandom_range(0, 63),
                   $urandom_range(0, 63), OCC_W'($urandom), LABEL_IN_W'($urandom));
      end
      return;
    end
    bias_class = occ_class_t'($urandom_range(0, 2));
    label_base = LABEL_IN_W'($urandom);
    for (int i = 0; i < 3; i++) begin
      lim = axis_limit(i);
      win_span[i] = (lim <= 6) ? lim : $urandom_range(3, 6);
      r = $urandom_range(0, 3);
      win_lo[i] = (r == 0) ? 0 : (r == 1) ? lim - win_span[i] :
                  $urandom_range(0, lim - win_span[i]);
    end
    in_grid_words = 0;
    while (in_grid_words < PHASE_WORDS) begin
      r = $urandom_range(0, 99);
      if (r < 10) begin
        a = $urandom_range(0, 2);
        for (int i = 0; i < 3; i++) begin
          c[i] = (i == a) ? $urandom_range(axis_limit(i), 63) : $urandom_range(0, 63);
        end
        queue_word(1'($urandom_range(0, 1)), c[0], c[1], c[2], rand_occ(), rand_label());
      end else if (r < 45) begin
        queue_word(MODE_WRITE, pick_coord(0), pick_coord(1), pick_coord(2), rand_occ(),
                   rand_label());
      end else begin
        x = pick_coord(0);
        y = pick_coord(1);
        z = pick_coord(2);
        r = $urandom_range(0, 99);
        if (r >= 85) begin
          // A solid block of one class and one label around the voxel.
          uniform_class = occ_class_t'($urandom_range(0, 2));
          lab = rand_label();
          for (int dx = -1; dx <= 1; dx++) begin
            for (int dy = -1; dy <= 1; dy++) begin
              for (int dz = -1; dz <= 1; dz++) begin
                if (in_grid(x + dx, y + dy, z + dz)) begin
                  queue_word(MODE_WRITE, x + dx, y + dy, z + dz,
                             occ_of_class(uniform_class), lab);
                end
              end
            end
          end
        end else if (r >= 70) begin
          // Most face neighbors get a label different from the center.
          lab = rand_label();
          queue_word(MODE_WRITE, x, y, z, rand_occ(), lab);
          for (int dx = -1; dx <= 1; dx++) begin
            for (int dy = -1; dy <= 1; dy++) begin
              for (int dz = -1; dz <= 1; dz++) begin
                if (((dx != 0) + (dy != 0) + (dz != 0)) == 1 &&
                    in_grid(x + dx, y + dy, z + dz) && $urandom_range(0, 3) != 0) begin
                  queue_word(MODE_WRITE, x + dx, y + dy, z + dz, rand_occ(),
                             lab ^ LABEL_IN_W'($urandom_range(1, 65535)));
                end
              end
            end
          end
        end
        fill_block(x, y, z);
        queue_word(MODE_QUERY, x, y, z, OCC_W'($urandom), LABEL_IN_W'($urandom));
      end
    end
  endtask

  initial begin
    grid_size[0] = SIZE_RESET;
    grid_size[1] = SIZE_RESET;
    grid_size[2] = SIZE_RESET;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Reset sizes: the far corner is in the grid, one step beyond it is not.
    queue_word(MODE_WRITE, 31, 31, 31, 16'hFFFF, 16'hFFFF);
    queue_word(MODE_WRITE, 32, 0, 0, 16'hFFFF, 16'h0001);
    queue_word(MODE_QUERY, 0, 0, 63, 16'h0000, 16'h0000);
    wait_drained();

    // A 2x2x1 grid with all three classes; the spare register address must be ignored.
    set_grid(2, 2, 1);
    reg_write(REG_SPARE, 6'd63);
    queue_word(MODE_WRITE, 0, 0, 0, 16'h0000, 16'h0000);
    queue_word(MODE_WRITE, 1, 0, 0, OCC_HALF, 16'hFFFF);
    queue_word(MODE_WRITE, 0, 1, 0, 16'hFFFF, 16'h0000);
    queue_word(MODE_WRITE, 1, 1, 0, OCC_HALF - OCC_W'(1), 16'h0000);
    queue_word(MODE_WRITE, 2, 0, 0, 16'hFFFF, 16'h0001);
    queue_word(MODE_WRITE, 0, 0, 1, 16'h1234, 16'h0002);
    queue_word(MODE_QUERY, 0, 0, 0, 16'h0000, 16'h0000);
    queue_word(MODE_QUERY, 1, 0, 0, 16'h0000, 16'h0000);
    queue_word(MODE_QUERY, 0, 1, 0, 16'h0000, 16'h0000);
    queue_word(MODE_QUERY, 1, 1, 0, 16'h0000, 16'h0000);
    queue_word(MODE_QUERY, 63, 63, 63, 16'hFFFF, 16'hFFFF);
    queue_word(MODE_QUERY, 0, 2, 0, 16'h0000, 16'h0000);
    queue_word(MODE_WRITE, 1, 1, 0, OCC_HALF + OCC_W'(1), 16'hFFFF);
    queue_word(MODE_QUERY, 1, 1, 0, 16'h0000, 16'h0000);
    queue_word(MODE_QUERY, 0, 0, 0, 16'h0000, 16'h0000);
    wait_drained();

    // A zero size register leaves no voxel in the grid.
    set_grid(0, 2, 1);
    queue_word(MODE_WRITE, 0, 0, 0, 16'hFFFF, 16'h0007);
    queue_word(MODE_QUERY, 0, 0, 0, 16'h0000, 16'h0000);
    wait_drained();

    for (int p = 0; p < 13; p++) begin
      set_grid(phase_sizes[p][0], phase_sizes[p][1], phase_sizes[p][2]);
      random_phase();
      wait_drained();
    end

    repeat (40) @(posedge clk);
    if (errors == 0) begin
      $display("PASS voxel_surface_and_corner_query");
    end else begin
      $display("FAIL voxel_surface_and_corner_query");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL voxel_surface_and_corner_query");
    $finish;
  end

endmodule

>>> files.f
design/vsq_pkg.sv
design/vsq_ctrl.sv
design/vsq_dp.sv
design/voxel_surface_and_corner_query.sv
verif/testbench.sv
